// ===== design/ptd_pkg.sv =====
// ptd_pkg: shared types and constants of the periodic task dispatcher
// holds item, result and queue entry types; no dependencies
package ptd_pkg;

    localparam int TIME_W = 48;
    localparam int PER_W  = 24;
    localparam int PRIO_W = 8;
    localparam int DL_W   = 24;
    localparam int SLOT_W = 4;
    localparam int ACT_W  = 2;
    localparam int POL_W  = 2;
    localparam int ADDR_W = 3;

    localparam logic [ADDR_W-1:0] ADDR_POLICY = 3'd0;

    localparam logic [ACT_W-1:0] ACT_REGISTER = 2'd0;
    localparam logic [ACT_W-1:0] ACT_COMPLETE = 2'd1;

    localparam logic [POL_W-1:0] POL_NP_FP  = 2'd0;
    localparam logic [POL_W-1:0] POL_NP_EDF = 2'd1;
    localparam logic [POL_W-1:0] POL_P_FP   = 2'd2;
    localparam logic [POL_W-1:0] POL_P_EDF  = 2'd3;

    localparam logic [TIME_W-1:0] TIME_MAX   = {TIME_W{1'b1}};
    localparam logic [PRIO_W-1:0] BOOST_MAX  = {PRIO_W{1'b1}};
    localparam logic [PRIO_W-1:0] BOOST_INIT = 8'd1;

    typedef enum logic [1:0] {
        EV_REGISTER = 2'd0,
        EV_COMPLETE = 2'd1,
        EV_TIMER    = 2'd2
    } ev_kind_t;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [TIME_W-1:0] now;
        logic [SLOT_W-1:0] task_slot;
        logic [PER_W-1:0]  period;
        logic [PRIO_W-1:0] priority_req;
        logic [DL_W-1:0]   deadline;
    } in_item_t;

    typedef struct packed {
        logic              dispatch_valid;
        logic [SLOT_W-1:0] dispatch_slot;
        logic [PRIO_W-1:0] dispatch_priority;
        logic              wake_valid;
        logic [TIME_W-1:0] wake_time;
        logic              reject;
    } out_item_t;

    typedef struct packed {
        ev_kind_t          kind;
        logic [TIME_W-1:0] now;
        logic [SLOT_W-1:0] task_slot;
        logic [PER_W-1:0]  period;
        logic [PRIO_W-1:0] prio;
        logic [DL_W-1:0]   deadline;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_chan_t;

endpackage

// ===== design/ptd_front.sv =====
// ptd_front: accepts event transactions, classifies them and queues them
// depends on ptd_pkg
module ptd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  ptd_pkg::in_item_t item,
    output ptd_pkg::cmd_chan_t chan,
    input  logic              take
);

    ptd_pkg::cmd_t q_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    ptd_pkg::cmd_t cmd_in;
    logic       do_push, do_pop;

    always_comb
    begin
        cmd_in.now       = item.now;
        cmd_in.task_slot = item.task_slot;
        cmd_in.period    = item.period;
        cmd_in.prio      = item.priority_req;
        cmd_in.deadline  = item.deadline;
        unique case (item.action)
            ptd_pkg::ACT_REGISTER: cmd_in.kind = ptd_pkg::EV_REGISTER;
            ptd_pkg::ACT_COMPLETE: cmd_in.kind = ptd_pkg::EV_COMPLETE;
            default:               cmd_in.kind = ptd_pkg::EV_TIMER;
        endcase
    end

    assign full       = cnt_reg == 2'd2;
    assign do_push    = push && !full;
    assign do_pop     = take && cnt_reg != 2'd0;
    assign chan.valid = cnt_reg != 2'd0;
    assign chan.cmd   = q_reg[rp_reg];

    always_comb
    begin
        wp_next  = do_push ? ~wp_reg : wp_reg;
        rp_next  = do_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wp_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== design/ptd_back.sv =====
// ptd_back: task table, slot scan, policy decision and result register
// depends on ptd_pkg
module ptd_back #(
    parameter int MAX_TASKS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [ptd_pkg::POL_W-1:0]         policy,
    input  ptd_pkg::cmd_chan_t                chan,
    output logic                              take,
    output logic                              empty,
    input  logic                              pop,
    output ptd_pkg::out_item_t                result
);

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int XW = (CW > ptd_pkg::SLOT_W) ? CW : ptd_pkg::SLOT_W;
    localparam int DW = ptd_pkg::TIME_W + 1;
    localparam int SW = ptd_pkg::TIME_W + 2;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_UPD  = 6'b000010,
        S_SCAN = 6'b000100,
        S_LAST = 6'b001000,
        S_DEC  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    typedef struct packed {
        logic [ptd_pkg::PER_W-1:0]  period;
        logic [ptd_pkg::PRIO_W-1:0] prio;
        logic [ptd_pkg::DL_W-1:0]   deadline;
    } prm_t;

    typedef struct packed {
        logic                       running;
        logic [ptd_pkg::PRIO_W-1:0] boost;
    } run_t;

    prm_t                        prm_mem [MAX_TASKS];
    logic [ptd_pkg::TIME_W-1:0]  rel_mem [MAX_TASKS];
    run_t                        run_mem [MAX_TASKS];

    state_t state_reg, state_next;
    ptd_pkg::cmd_t cur_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          ev_reg;
    logic [IW-1:0] ev_idx_reg;
    prm_t                       prm_q;
    logic [ptd_pkg::TIME_W-1:0] rel_q;
    run_t                       run_q;
    logic          rej_reg, rej_next;

    logic                       sh_reg, sh_next;
    logic [IW-1:0]              s_idx_reg, s_idx_next;
    logic [DW-1:0]              s_dl_reg, s_dl_next;
    logic [ptd_pkg::PRIO_W-1:0] s_prio_reg, s_prio_next;
    logic                       s_run_reg, s_run_next;
    logic [ptd_pkg::TIME_W-1:0] s_rel_reg, s_rel_next;
    logic [ptd_pkg::PER_W-1:0]  s_per_reg, s_per_next;
    logic [ptd_pkg::PRIO_W-1:0] s_boost_reg, s_boost_next;
    logic                       rh_reg, rh_next;
    logic signed [SW-1:0]       r_dl_reg, r_dl_next;
    logic [ptd_pkg::PRIO_W-1:0] r_prio_reg, r_prio_next;
    logic [ptd_pkg::PRIO_W-1:0] r_boost_reg, r_boost_next;
    logic                       fh_reg, fh_next;
    logic [ptd_pkg::TIME_W-1:0] f_time_reg, f_time_next;

    ptd_pkg::out_item_t res_reg, res_next;
    ptd_pkg::out_item_t out_reg;
    logic               out_vld_reg, out_vld_next;

    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          prm_we, rel_we, run_we;
    logic [IW-1:0] wr_addr;
    prm_t          prm_wd;
    logic [ptd_pkg::TIME_W-1:0] rel_wd;
    run_t          run_wd;

    logic          due, cand, better;
    logic [DW-1:0] q_dl;
    logic signed [SW-1:0] q_pd, sel_sd;
    logic [DW-1:0] sum_reg_add, sum_adv;
    logic [ptd_pkg::TIME_W-1:0] adv_rel, reg_rel;
    logic [XW-1:0] slot_x, cnt_x;
    logic          go;
    logic [ptd_pkg::PRIO_W-1:0] boost_new;

    assign take   = (state_reg == S_IDLE) && chan.valid;
    assign empty  = !out_vld_reg;
    assign result = out_reg;

    assign sum_reg_add = {1'b0, cur_reg.now} + DW'(cur_reg.period);
    assign reg_rel     = sum_reg_add[DW-1] ? ptd_pkg::TIME_MAX : sum_reg_add[DW-2:0];
    assign sum_adv     = {1'b0, s_rel_reg} + DW'(s_per_reg);
    assign adv_rel     = sum_adv[DW-1] ? ptd_pkg::TIME_MAX : sum_adv[DW-2:0];
    assign slot_x      = XW'(cur_reg.task_slot);
    assign cnt_x       = XW'(cnt_reg);

    assign due    = rel_q <= cur_reg.now;
    assign q_dl   = {1'b0, rel_q} + DW'(prm_q.deadline);
    assign q_pd   = $signed({2'b00, rel_q}) - $signed(SW'(prm_q.period))
                  + $signed(SW'(prm_q.deadline));
    assign sel_sd = $signed({1'b0, s_dl_reg});
    assign cand   = (policy == ptd_pkg::POL_P_FP) ? (run_q.running || due) : due;

    always_comb
    begin
        if (!sh_reg)
        begin
            better = 1'b1;
        end
        else if (!policy[0])
        begin
            better = prm_q.prio > s_prio_reg;
        end
        else
        begin
            better = (q_dl < s_dl_reg) || ((q_dl == s_dl_reg) && (prm_q.prio > s_prio_reg));
        end
    end

    always_comb
    begin
        go = sh_reg;
        if (policy == ptd_pkg::POL_P_FP)
        begin
            go = sh_reg && !s_run_reg;
        end
        else if (policy == ptd_pkg::POL_P_EDF && sh_reg && rh_reg)
        begin
            if (sel_sd > r_dl_reg || (sel_sd == r_dl_reg && s_prio_reg < r_prio_reg))
            begin
                go = 1'b0;
            end
        end
        boost_new = ptd_pkg::BOOST_INIT;
        if (rh_reg)
        begin
            boost_new = (r_boost_reg == ptd_pkg::BOOST_MAX) ? ptd_pkg::BOOST_MAX
                                                          : r_boost_reg + 8'd1;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        rej_next     = rej_reg;
        res_next     = res_reg;
        out_vld_next = out_vld_reg;
        rd_en   = 1'b0;
        rd_addr = idx_reg;
        prm_we  = 1'b0;
        rel_we  = 1'b0;
        run_we  = 1'b0;
        wr_addr = cnt_reg[IW-1:0];
        prm_wd  = '{period: cur_reg.period, prio: cur_reg.prio, deadline: cur_reg.deadline};
        rel_wd  = reg_rel;
        run_wd  = '{running: 1'b0, boost: ptd_pkg::BOOST_INIT};

        sh_next      = sh_reg;
        s_idx_next   = s_idx_reg;
        s_dl_next    = s_dl_reg;
        s_prio_next  = s_prio_reg;
        s_run_next   = s_run_reg;
        s_rel_next   = s_rel_reg;
        s_per_next   = s_per_reg;
        s_boost_next = s_boost_reg;
        rh_next      = rh_reg;
        r_dl_next    = r_dl_reg;
        r_prio_next  = r_prio_reg;
        r_boost_next = r_boost_reg;
        fh_next      = fh_reg;
        f_time_next  = f_time_reg;

        if (pop && out_vld_reg)
        begin
            out_vld_next = 1'b0;
        end

        if (ev_reg)
        begin
            if (cand && better)
            begin
                sh_next      = 1'b1;
                s_idx_next   = ev_idx_reg;
                s_dl_next    = q_dl;
                s_prio_next  = prm_q.prio;
                s_run_next   = run_q.running;
                s_rel_next   = rel_q;
                s_per_next   = prm_q.period;
                s_boost_next = run_q.boost;
            end
            if (run_q.running && (!rh_reg || q_pd < r_dl_reg
                || (q_pd == r_dl_reg && prm_q.prio > r_prio_reg)))
            begin
                rh_next      = 1'b1;
                r_dl_next    = q_pd;
                r_prio_next  = prm_q.prio;
                r_boost_next = run_q.boost;
            end
            if (!due && (!fh_reg || rel_q < f_time_reg))
            begin
                fh_next     = 1'b1;
                f_time_next = rel_q;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (chan.valid)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                rej_next = 1'b0;
                sh_next  = 1'b0;
                rh_next  = 1'b0;
                fh_next  = 1'b0;
                idx_next = '0;
                if (cur_reg.kind == ptd_pkg::EV_REGISTER)
                begin
                    if (cnt_reg >= CW'(MAX_TASKS))
                    begin
                        rej_next = 1'b1;
                    end
                    else
                    begin
                        prm_we   = 1'b1;
                        rel_we   = 1'b1;
                        run_we   = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                else if (cur_reg.kind == ptd_pkg::EV_COMPLETE && slot_x < cnt_x)
                begin
                    run_we  = 1'b1;
                    wr_addr = IW'(slot_x);
                end
                if (cnt_next == '0)
                begin
                    res_next   = '0;
                    res_next.reject = rej_next;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                rd_en    = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (CW'(idx_reg) == cnt_reg - 1'b1)
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                state_next = S_DEC;
            end
            S_DEC:
            begin
                res_next        = '0;
                res_next.reject = rej_reg;
                wr_addr         = s_idx_reg;
                rel_wd          = adv_rel;
                if (policy[1] || !go)
                begin
                    res_next.wake_valid = fh_reg;
                    res_next.wake_time  = fh_reg ? f_time_reg : '0;
                end
                if (go)
                begin
                    rel_we = 1'b1;
                    res_next.dispatch_valid = 1'b1;
                    res_next.dispatch_slot  = ptd_pkg::SLOT_W'(s_idx_reg);
                    unique case (policy)
                        ptd_pkg::POL_P_FP:
                        begin
                            run_we = 1'b1;
                            run_wd = '{running: 1'b1, boost: s_boost_reg};
                            res_next.dispatch_priority = s_prio_reg;
                        end
                        ptd_pkg::POL_P_EDF:
                        begin
                            run_we = 1'b1;
                            run_wd = '{running: 1'b1, boost: boost_new};
                            res_next.dispatch_priority = boost_new;
                        end
                        default:
                        begin
                            res_next.dispatch_priority = 8'd1;
                        end
                    endcase
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_vld_next)
                begin
                    out_vld_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (prm_we)
        begin
            prm_mem[wr_addr] <= prm_wd;
        end
        if (rel_we)
        begin
            rel_mem[wr_addr] <= rel_wd;
        end
        if (run_we)
        begin
            run_mem[wr_addr] <= run_wd;
        end
        if (rd_en)
        begin
            prm_q <= prm_mem[rd_addr];
            rel_q <= rel_mem[rd_addr];
            run_q <= run_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cur_reg <= chan.cmd;
        end
        ev_idx_reg  <= idx_reg;
        s_idx_reg   <= s_idx_next;
        s_dl_reg    <= s_dl_next;
        s_prio_reg  <= s_prio_next;
        s_run_reg   <= s_run_next;
        s_rel_reg   <= s_rel_next;
        s_per_reg   <= s_per_next;
        s_boost_reg <= s_boost_next;
        r_dl_reg    <= r_dl_next;
        r_prio_reg  <= r_prio_next;
        r_boost_reg <= r_boost_next;
        f_time_reg  <= f_time_next;
        res_reg     <= res_next;
        rej_reg     <= rej_next;
        if (state_reg == S_OUT && (!out_vld_reg || pop))
        begin
            out_reg <= res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            idx_reg     <= '0;
            ev_reg      <= 1'b0;
            sh_reg      <= 1'b0;
            rh_reg      <= 1'b0;
            fh_reg      <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            ev_reg      <= rd_en;
            sh_reg      <= sh_next;
            rh_reg      <= rh_next;
            fh_reg      <= fh_next;
            out_vld_reg <= out_vld_next;
        end
    end

endmodule

// ===== design/periodic_task_dispatcher.sv =====
// periodic_task_dispatcher: top level, configuration port and assertions
// depends on ptd_pkg, ptd_front and ptd_back
// Each event transaction is queued by the front (two entries) and handled by
// the back after it is accepted in these steps: taking it from the queue, a
// table update, one read of the task table per registered slot, a step for the
// last read to settle, a decision and loading the result register. With an
// empty table the scan is skipped. The scan reads the table through a single
// read port. A result that waits for pop holds the back, so later events wait
// in the front. The user writes the policy at address 0 only while no
// transaction is in flight; the block itself does not enforce this.
module periodic_task_dispatcher #(
    parameter int MAX_TASKS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  ptd_pkg::in_item_t            item,
    output logic                         empty,
    input  logic                         pop,
    output ptd_pkg::out_item_t           result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ptd_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    logic [ptd_pkg::POL_W-1:0] policy_reg, policy_next;
    ptd_pkg::cmd_chan_t chan;
    logic take;

    assign pready = 1'b1;
    assign prdata = (paddr == ptd_pkg::ADDR_POLICY) ? {30'd0, policy_reg} : 32'd0;

    always_comb
    begin
        policy_next = policy_reg;
        if (psel && penable && pwrite && paddr == ptd_pkg::ADDR_POLICY)
        begin
            policy_next = pwdata[ptd_pkg::POL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= ptd_pkg::POL_NP_FP;
        end
        else
        begin
            policy_reg <= policy_next;
        end
    end

    ptd_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .item  (item),
        .chan  (chan),
        .take  (take)
    );

    ptd_back #(
        .MAX_TASKS (MAX_TASKS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .policy (policy_reg),
        .chan   (chan),
        .take   (take),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    a_disp_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.dispatch_valid) |->
            (result.dispatch_slot == '0 && result.dispatch_priority == '0))
        else $error("dispatch fields set without dispatch");

    a_wake_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.wake_valid) |-> (result.wake_time == '0))
        else $error("wake time set without wake");

    a_np_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !policy_reg[1] && result.dispatch_valid) |->
            (!result.wake_valid && result.dispatch_priority == 8'd1))
        else $error("non-preemptive dispatch with wake or wrong priority");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && paddr == ptd_pkg::ADDR_POLICY) |=>
            (policy_reg == $past(pwdata[ptd_pkg::POL_W-1:0])))
        else $error("policy write lost");

endmodule

// ===== bench/testbench.sv =====
// testbench: self-checking bench of periodic_task_dispatcher
// drives event transactions through the queue ports, predicts every result
// with an own model of the task table; depends on ptd_pkg and the design
module testbench;

    localparam int NTASK = 16;
    localparam logic [ptd_pkg::ACT_W-1:0] ACT_SPARE = 2'd3;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       push = 1'b0;
    logic                       full;
    ptd_pkg::in_item_t          item = '0;
    logic                       empty;
    logic                       pop = 1'b0;
    ptd_pkg::out_item_t         result;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [ptd_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0]                pwdata = '0;
    logic [31:0]                prdata;
    logic                       pready;

    periodic_task_dispatcher #(.MAX_TASKS(NTASK)) i_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .item(item),
        .empty(empty), .pop(pop), .result(result), .psel(psel),
        .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    // model copy of the task table
    logic [ptd_pkg::POL_W-1:0]  cur_policy;
    int                         task_total;
    logic [ptd_pkg::PER_W-1:0]  t_period [NTASK];
    logic [ptd_pkg::PRIO_W-1:0] t_prio [NTASK];
    logic [ptd_pkg::DL_W-1:0]   t_deadline [NTASK];
    logic [ptd_pkg::TIME_W-1:0] t_release [NTASK];
    logic                       t_running [NTASK];
    logic [ptd_pkg::PRIO_W-1:0] t_boost [NTASK];

    ptd_pkg::out_item_t dispatch_q [$];
    int          errors = 0;
    int          sent = 0;
    int          checked = 0;
    bit          quiet = 1'b0;
    int          pop_hold = 0;
    logic [ptd_pkg::TIME_W-1:0] clock_ms = '0;

    function automatic logic [ptd_pkg::TIME_W-1:0] sat_add(
        logic [ptd_pkg::TIME_W-1:0] a, logic [ptd_pkg::PER_W-1:0] b);
        logic [ptd_pkg::TIME_W:0] s;
        s = {1'b0, a} + b;
        return s[ptd_pkg::TIME_W] ? ptd_pkg::TIME_MAX : s[ptd_pkg::TIME_W-1:0];
    endfunction

    function automatic ptd_pkg::out_item_t dispatch_predict(ptd_pkg::in_item_t it);
        ptd_pkg::out_item_t         o;
        int                         n;
        bit                         have;
        bit                         any_future;
        bit                         have_run;
        bit                         used [NTASK];
        bit                         found;
        int                         sel;
        int                         run;
        int                         best;
        logic [63:0]                sel_dl;
        logic [63:0]                dl;
        logic [ptd_pkg::TIME_W-1:0] next;
        logic [ptd_pkg::TIME_W-1:0] r;
        longint                     run_dl;
        longint                     pd;
        logic [ptd_pkg::PRIO_W-1:0] b;
        o = '0;
        if (it.action == ptd_pkg::ACT_REGISTER)
        begin
            if (task_total >= NTASK)
            begin
                o.reject = 1'b1;
            end
            else
            begin
                t_period[task_total] = it.period;
                t_prio[task_total] = it.priority_req;
                t_deadline[task_total] = it.deadline;
                t_release[task_total] = sat_add(it.now, it.period);
                t_running[task_total] = 1'b0;
                t_boost[task_total] = ptd_pkg::BOOST_INIT;
                task_total++;
            end
        end
        else if (it.action == ptd_pkg::ACT_COMPLETE)
        begin
            if (int'(it.task_slot) < task_total)
            begin
                t_running[it.task_slot] = 1'b0;
                t_boost[it.task_slot] = ptd_pkg::BOOST_INIT;
            end
        end
        n = task_total;
        if (n == 0)
            return o;
        have = 0;
        any_future = 0;
        sel = 0;
        sel_dl = '0;
        next = ptd_pkg::TIME_MAX;
        if (cur_policy == ptd_pkg::POL_NP_FP || cur_policy == ptd_pkg::POL_NP_EDF)
        begin
            for (int i = 0; i < n; i++)
            begin
                r = t_release[i];
                if (r <= it.now)
                begin
                    dl = 64'(r) + 64'(t_deadline[i]);
                    if (!have ||
                        (cur_policy == ptd_pkg::POL_NP_FP && t_prio[i] > t_prio[sel]) ||
                        (cur_policy == ptd_pkg::POL_NP_EDF && (dl < sel_dl ||
                         (dl == sel_dl && t_prio[i] > t_prio[sel]))))
                    begin
                        have = 1;
                        sel = i;
                        sel_dl = dl;
                    end
                end
                else if (!any_future || r < next)
                begin
                    any_future = 1;
                    next = r;
                end
            end
            if (have)
            begin
                t_release[sel] = sat_add(t_release[sel], t_period[sel]);
                o.dispatch_valid = 1'b1;
                o.dispatch_slot = sel[ptd_pkg::SLOT_W-1:0];
                o.dispatch_priority = 8'd1;
            end
            else if (any_future)
            begin
                o.wake_valid = 1'b1;
                o.wake_time = next;
            end
            return o;
        end
        for (int i = 0; i < n; i++)
        begin
            r = t_release[i];
            if (r > it.now && (!any_future || r < next))
            begin
                any_future = 1;
                next = r;
            end
        end
        if (any_future)
        begin
            o.wake_valid = 1'b1;
            o.wake_time = next;
        end
        if (cur_policy == ptd_pkg::POL_P_FP)
        begin
            foreach (used[i]) used[i] = 0;
            for (int k = 0; k < n; k++)
            begin
                best = 0;
                found = 0;
                for (int i = 0; i < n; i++)
                begin
                    if (!used[i] && (!found || t_prio[i] > t_prio[best]))
                    begin
                        found = 1;
                        best = i;
                    end
                end
                used[best] = 1;
                if (t_running[best])
                    break;
                if (t_release[best] <= it.now)
                begin
                    t_release[best] = sat_add(t_release[best], t_period[best]);
                    t_running[best] = 1'b1;
                    o.dispatch_valid = 1'b1;
                    o.dispatch_slot = best[ptd_pkg::SLOT_W-1:0];
                    o.dispatch_priority = t_prio[best];
                    break;
                end
            end
            return o;
        end
        have_run = 0;
        run = 0;
        run_dl = 0;
        for (int i = 0; i < n; i++)
        begin
            r = t_release[i];
            if (t_running[i])
            begin
                pd = longint'(r) - longint'(t_period[i]) + longint'(t_deadline[i]);
                if (!have_run || pd < run_dl ||
                    (pd == run_dl && t_prio[i] > t_prio[run]))
                begin
                    have_run = 1;
                    run = i;
                    run_dl = pd;
                end
            end
            if (r <= it.now)
            begin
                dl = 64'(r) + 64'(t_deadline[i]);
                if (!have || dl < sel_dl || (dl == sel_dl && t_prio[i] > t_prio[sel]))
                begin
                    have = 1;
                    sel = i;
                    sel_dl = dl;
                end
            end
        end
        if (have && have_run)
        begin
            if (longint'(sel_dl) > run_dl ||
                (longint'(sel_dl) == run_dl && t_prio[sel] < t_prio[run]))
                have = 0;
        end
        if (have)
        begin
            b = ptd_pkg::BOOST_INIT;
            if (have_run)
                b = (t_boost[run] == ptd_pkg::BOOST_MAX) ? ptd_pkg::BOOST_MAX
                                                         : t_boost[run] + 8'd1;
            t_release[sel] = sat_add(t_release[sel], t_period[sel]);
            t_running[sel] = 1'b1;
            t_boost[sel] = b;
            o.dispatch_valid = 1'b1;
            o.dispatch_slot = sel[ptd_pkg::SLOT_W-1:0];
            o.dispatch_priority = b;
        end
        return o;
    endfunction

    // result side: random pop stalls and comparison with the oldest prediction
    always @(posedge clk)
    begin
        ptd_pkg::out_item_t e;
        if (pop && !empty)
        begin
            if (dispatch_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, result);
                errors++;
            end
            else
            begin
                e = dispatch_q.pop_front();
                checked++;
                if (e.dispatch_valid !== result.dispatch_valid)
                begin
                    $display("%0t: dispatch_valid exp %h got %h", $time,
                             e.dispatch_valid, result.dispatch_valid);
                    errors++;
                end
                if (e.dispatch_slot !== result.dispatch_slot)
                begin
                    $display("%0t: dispatch_slot exp %h got %h", $time,
                             e.dispatch_slot, result.dispatch_slot);
                    errors++;
                end
                if (e.dispatch_priority !== result.dispatch_priority)
                begin
                    $display("%0t: dispatch_priority exp %h got %h", $time,
                             e.dispatch_priority, result.dispatch_priority);
                    errors++;
                end
                if (e.wake_valid !== result.wake_valid)
                begin
                    $display("%0t: wake_valid exp %h got %h", $time,
                             e.wake_valid, result.wake_valid);
                    errors++;
                end
                if (e.wake_time !== result.wake_time)
                begin
                    $display("%0t: wake_time exp %h got %h", $time,
                             e.wake_time, result.wake_time);
                    errors++;
                end
                if (e.reject !== result.reject)
                begin
                    $display("%0t: reject exp %h got %h", $time, e.reject, result.reject);
                    errors++;
                end
            end
        end
        if (pop_hold > 0)
        begin
            pop_hold--;
            pop <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            pop_hold = $urandom_range(1, 13) - 1;
            pop <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    task automatic send_event(ptd_pkg::in_item_t it);
        ptd_pkg::out_item_t p;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full) @(posedge clk);
        p = dispatch_predict(it);
        dispatch_q.insert(dispatch_q.size(), p);
        sent++;
    endtask

    task automatic send_fields(logic [ptd_pkg::ACT_W-1:0] act,
                               logic [ptd_pkg::TIME_W-1:0] now_ms,
                               logic [ptd_pkg::SLOT_W-1:0] slot,
                               logic [ptd_pkg::PER_W-1:0] per,
                               logic [ptd_pkg::PRIO_W-1:0] prio,
                               logic [ptd_pkg::DL_W-1:0] dl);
        ptd_pkg::in_item_t it;
        it.action = act;
        it.now = now_ms;
        it.task_slot = slot;
        it.period = per;
        it.priority_req = prio;
        it.deadline = dl;
        send_event(it);
    endtask

    // sender pauses until every prediction has been matched
    task automatic drain;
        push <= 1'b0;
        @(posedge clk);
        while (dispatch_q.size() != 0) @(posedge clk);
        repeat (NTASK + 10) @(posedge clk);
    endtask

    task automatic write_policy(logic [ptd_pkg::POL_W-1:0] pol);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ptd_pkg::ADDR_POLICY;
        pwdata <= 32'(pol);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cur_policy = pol;
    endtask

    task automatic test_empty_table;
        send_fields(ptd_pkg::EV_TIMER, 48'd0, 4'd0, 24'd1, 8'd0, 24'd0);
        send_fields(ptd_pkg::ACT_COMPLETE, 48'd3, 4'd3, 24'd1, 8'd0, 24'd0);
        send_fields(ACT_SPARE, 48'd5, 4'd15, 24'hFFFFFF, 8'hFF, 24'hFFFFFF);
    endtask

    task automatic test_table_extremes;
        send_fields(ptd_pkg::ACT_REGISTER, 48'd0, 4'd0, 24'd1, 8'd0, 24'd0);
        send_fields(ptd_pkg::ACT_REGISTER, 48'd0, 4'd9, 24'd10, 8'hFF, 24'hFFFFFF);
        send_fields(ptd_pkg::ACT_REGISTER, ptd_pkg::TIME_MAX - 48'd3, 4'd0, 24'hFFFFFF,
                    8'd128, 24'd5);
        send_fields(ptd_pkg::ACT_REGISTER, 48'd1, 4'd6, 24'd3, 8'hFF, 24'd2);
        send_fields(ptd_pkg::EV_TIMER, 48'd20, 4'd0, 24'd0, 8'd0, 24'd0);
        send_fields(ptd_pkg::EV_TIMER, 48'd20, 4'd0, 24'd0, 8'd0, 24'd0);
        send_fields(ptd_pkg::ACT_COMPLETE, 48'd21, 4'd1, 24'd0, 8'd0, 24'd0);
        send_fields(ptd_pkg::ACT_COMPLETE, 48'd21, 4'd15, 24'd0, 8'd0, 24'd0);
        send_fields(ptd_pkg::EV_TIMER, ptd_pkg::TIME_MAX, 4'd0, 24'd0, 8'd0, 24'd0);
        drain();
    endtask

    task automatic test_each_policy;
        for (int p = 1; p < 4; p++)
        begin
            write_policy(p[ptd_pkg::POL_W-1:0]);
            send_fields(ptd_pkg::EV_TIMER, 48'd40, 4'd0, 24'd0, 8'd0, 24'd0);
            send_fields(ptd_pkg::EV_TIMER, 48'd60, 4'd0, 24'd0, 8'd0, 24'd0);
            send_fields(ptd_pkg::ACT_COMPLETE, 48'd61, 4'd3, 24'd0, 8'd0, 24'd0);
            drain();
        end
    endtask

    task automatic test_random(logic [ptd_pkg::POL_W-1:0] pol, int count);
        ptd_pkg::in_item_t it;
        int                pick;
        write_policy(pol);
        for (int k = 0; k < count; k++)
        begin
            clock_ms = clock_ms + ptd_pkg::TIME_W'($urandom_range(0, 40));
            pick = $urandom_range(0, 99);
            it.action = (pick < 15) ? ptd_pkg::ACT_REGISTER :
                        (pick < 50) ? ptd_pkg::ACT_COMPLETE :
                        (pick < 95) ? ptd_pkg::ACT_W'(ptd_pkg::EV_TIMER) : ACT_SPARE;
            it.now = ($urandom_range(0, 49) == 0) ?
                     ptd_pkg::TIME_W'({$urandom, $urandom}) : clock_ms;
            it.task_slot = ptd_pkg::SLOT_W'($urandom);
            it.period = ($urandom_range(0, 19) == 0) ? ptd_pkg::PER_W'($urandom) :
                        ptd_pkg::PER_W'($urandom_range(1, 200));
            if (it.period == 0)
                it.period = 24'd1;
            it.priority_req = ptd_pkg::PRIO_W'($urandom);
            it.deadline = ($urandom_range(0, 19) == 0) ? ptd_pkg::DL_W'($urandom) :
                          ptd_pkg::DL_W'($urandom_range(0, 300));
            send_event(it);
        end
        drain();
    endtask

    initial
    begin
        cur_policy = ptd_pkg::POL_NP_FP;
        task_total = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_policy(ptd_pkg::POL_NP_FP);
        test_empty_table();
        test_table_extremes();
        test_each_policy();
        test_random(ptd_pkg::POL_NP_EDF, 250);
        test_random(ptd_pkg::POL_P_EDF, 250);
        test_random(ptd_pkg::POL_NP_FP, 200);
        test_random(ptd_pkg::POL_P_FP, 200);
        quiet = 1'b1;
        test_random(ptd_pkg::POL_P_EDF, 100);
        $display("covered %0d events over all four policies, full and empty table,", sent);
        $display("time saturation and random stalls; %0d results compared", checked);
        if (errors == 0 && dispatch_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/ptd_pkg.sv
design/ptd_front.sv
design/ptd_back.sv
design/periodic_task_dispatcher.sv
bench/testbench.sv
